FILE: hdl/drrq_pkg.sv
// Shared types and constants for the directional resource request queues.
// No dependencies.
`timescale 1ns / 1ps
package drrq_pkg;
   localparam int unsigned STAMP_W = 32;
   localparam int unsigned AGENT_W = 4;
   localparam int unsigned DIR_W   = 2;
   localparam int unsigned CAP_W   = 5;
   localparam int unsigned NUM_CAP = 4;
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_CHOOSE  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_IDLE = '0;
   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   // One queue slot as held in memory
   typedef struct packed {
      logic [AGENT_W-1:0] agent;
      logic [STAMP_W-1:0] stamp;
   } slot_type;
endpackage

FILE: hdl/drrq_slot_ram.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on drrq_pkg.
`timescale 1ns / 1ps
module drrq_slot_ram import drrq_pkg::*; #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  slot_type          wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output slot_type          rd_data
);
   slot_type mem [DEPTH];

   // Write and read; read data is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/directional_resource_request_queues.sv
// Top level of the directional resource request queues.
// Depends on drrq_pkg and drrq_slot_ram.
`timescale 1ns / 1ps
// Usage:
// One item enters on req_ (tdata: kind, requester, resource, travel_dir,
// stamp from bit 0 up). One result beat leaves on rsp_ per item (tdata:
// ack_valid, ack_to, clock_now, best_found, best_res from bit 0 up).
// The user writes capacities on csr_ while the block is idle (unchecked).
// Items are handled one at a time by a sequencer around one slot memory
// (NUM_RES*MAX_AGENTS entries, one read and one write per cycle).
// Before rsp_tvalid, a request reads and checks each slot of its queue,
// then, unless already queued or full, shifts up the slots from its place
// and inserts; release scans for the requester and shifts later slots down;
// choose reads the queues in order, stopping at one in its direction below
// capacity; an unused kind is done at once. The registered memory read sets
// the scan pace. req_tready rises the cycle after the result is handed on.
// Reset clears lengths, directions, clock and capacities (to 4); slot
// contents are never cleared since only slots below a queue's length
// are read. A stalled rsp_ holds its beat; a finished item waits for the
// output register to empty, and req_ is taken again once its result has
// moved into that register, even while that beat is still stalled.
module directional_resource_request_queues import drrq_pkg::*; #(
   parameter int unsigned NUM_RES = 4,
   parameter int unsigned MAX_AGENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[1:0], requester[5:2], resource[7:6], travel_dir[9:8],
   // stamp[41:10], zero fill
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ack_valid[0], ack_to[4:1], clock_now[36:5], best_found[37],
   // best_res[39:38]
   output logic [39:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);
   localparam int unsigned RES_W  = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
   localparam int unsigned LEN_W  = $clog2(MAX_AGENTS + 1);
   localparam int unsigned ADDR_W = $clog2(NUM_RES * MAX_AGENTS);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_AGENTS);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RD     = 4'd1;
   localparam logic [3:0] ST_CHK    = 4'd2;
   localparam logic [3:0] ST_INS    = 4'd3;
   localparam logic [3:0] ST_SHUP   = 4'd4;
   localparam logic [3:0] ST_SHDN   = 4'd5;
   localparam logic [3:0] ST_CRES   = 4'd6;
   localparam logic [3:0] ST_DONE   = 4'd7;
   localparam logic [3:0] ST_SHUPW  = 4'd8;
   localparam logic [3:0] ST_SHDNW  = 4'd9;

   // Registers
   logic [3:0]         state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [AGENT_W-1:0] agent_ff, agent_in;
   logic [1:0]         res_ff, res_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic               pos_set_ff, pos_set_in;
   logic               hit_ff, hit_in;
   logic [RES_W-1:0]   cr_ff, cr_in;
   logic               idle_v_ff, idle_v_in, full_v_ff, full_v_in;
   logic [RES_W-1:0]   idle_r_ff, idle_r_in, full_r_ff, full_r_in;
   logic               pick_v_ff, pick_v_in;
   logic [RES_W-1:0]   pick_r_ff, pick_r_in;
   logic [LEN_W-1:0]   len_ff [NUM_RES];
   logic [DIR_W-1:0]   rdir_ff [NUM_RES];
   logic [CAP_W-1:0]   cap_ff [NUM_CAP];
   logic [STAMP_W-1:0] clk_ff;
   logic               ov_ff;
   logic [39:0]        od_ff;

   // Memory ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   slot_type          wr_data, rd_data;

   drrq_slot_ram #(.DEPTH(NUM_RES * MAX_AGENTS), .ADDR_W(ADDR_W)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   function automatic logic [ADDR_W-1:0] addr_of(input logic [RES_W-1:0] r,
                                                 input logic [LEN_W-1:0] i);
      logic [ADDR_W+LEN_W-1:0] a;
      begin
         a = (ADDR_W+LEN_W)'(r) * (ADDR_W+LEN_W)'(MAX_AGENTS)
             + (ADDR_W+LEN_W)'(i);
         return a[ADDR_W-1:0];
      end
   endfunction

   logic               res_ok;
   logic [RES_W-1:0]   rr, crr;
   logic [LEN_W-1:0]   cur_len, c_len;
   logic [DIR_W-1:0]   c_dir;
   logic [CAP_W-1:0]   c_cap;
   logic [STAMP_W-1:0] nxt_clk;
   logic               goes_before, lower;
   logic               accept, fin;

   assign res_ok  = 32'(res_ff) < NUM_RES;
   assign rr      = RES_W'(res_ff);
   assign cur_len = res_ok ? len_ff[rr] : '0;
   assign crr     = cr_ff;
   assign c_len   = len_ff[crr];
   assign c_dir   = rdir_ff[crr];
   assign c_cap   = cap_ff[2'(crr)];
   assign nxt_clk = (stamp_ff == STAMP_MAX) ? stamp_ff : stamp_ff + 1'b1;
   assign goes_before = (rd_data.stamp > stamp_ff) ||
                        ((rd_data.stamp == stamp_ff) && (rd_data.agent >= agent_ff));
   assign lower = (LEN_W'(CAP_W'(c_len)) == c_len) ? (CAP_W'(c_len) < c_cap)
                                                    : 1'b0;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer: scan, shift and choose over the slot memory
   always_comb begin
      state_in = state_ff; kind_in = kind_ff; agent_in = agent_ff;
      res_in = res_ff; dir_in = dir_ff; stamp_in = stamp_ff;
      idx_in = idx_ff; pos_in = pos_ff; pos_set_in = pos_set_ff;
      hit_in = hit_ff; cr_in = cr_ff; idle_v_in = idle_v_ff;
      full_v_in = full_v_ff; idle_r_in = idle_r_ff; full_r_in = full_r_ff;
      pick_v_in = pick_v_ff; pick_r_in = pick_r_ff;
      wr_en = 1'b0; wr_addr = addr_of(rr, idx_ff);
      wr_data = '{agent: agent_ff, stamp: stamp_ff};
      rd_addr = addr_of(rr, idx_ff);
      fin = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_tdata[1:0]; agent_in = req_tdata[5:2];
               res_in = req_tdata[7:6]; dir_in = req_tdata[9:8];
               stamp_in = req_tdata[41:10];
               idx_in = '0; pos_set_in = 1'b0; hit_in = 1'b0;
               cr_in = '0; idle_v_in = 1'b0; full_v_in = 1'b0; pick_v_in = 1'b0;
               case (req_tdata[1:0])
                  KIND_REQUEST, KIND_RELEASE: state_in = ST_RD;
                  KIND_CHOOSE: state_in = ST_CRES;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RD: begin
            // Issue read of slot idx or finish the scan
            if (idx_ff >= cur_len) begin
               if (kind_ff == KIND_REQUEST) begin
                  if (!res_ok || hit_ff || (cur_len >= LEN_FULL && cur_len != '0)) begin
                     state_in = ST_DONE;
                  end else begin
                     if (!pos_set_ff) pos_in = cur_len;
                     idx_in = cur_len;
                     state_in = ST_SHUP;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (kind_ff == KIND_REQUEST) begin
               if (rd_data.agent == agent_ff) hit_in = 1'b1;
               if (!pos_set_ff && goes_before) begin
                  pos_set_in = 1'b1; pos_in = idx_ff;
               end
               idx_in = idx_ff + 1'b1;
               state_in = ST_RD;
            end else if (rd_data.agent == agent_ff) begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_SHDN;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_SHUP: begin
            // Move slot idx-1 up to idx, down to pos
            if (idx_ff == pos_ff) begin
               state_in = ST_INS;
            end else begin
               rd_addr = addr_of(rr, idx_ff - 1'b1);
               state_in = ST_SHUPW;
            end
         end
         ST_SHUPW: begin
            wr_en = 1'b1; wr_data = rd_data;
            idx_in = idx_ff - 1'b1;
            state_in = ST_SHUP;
         end
         ST_INS: begin
            wr_en = 1'b1;
            state_in = ST_DONE;
         end
         ST_SHDN: begin
            // Move slot idx down to idx-1 up to the tail
            if (idx_ff >= cur_len) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHDNW;
            end
         end
         ST_SHDNW: begin
            wr_en = 1'b1; wr_addr = addr_of(rr, idx_ff - 1'b1); wr_data = rd_data;
            idx_in = idx_ff + 1'b1;
            rd_addr = addr_of(rr, idx_ff + 1'b1);
            state_in = ST_SHDN;
         end
         ST_CRES: begin
            // Scan queue cr for the requester: idx counts issued reads,
            // pos_set marks that a read is in flight
            rd_addr = addr_of(crr, idx_ff);
            if (pos_set_ff && rd_data.agent == agent_ff) hit_in = 1'b1;
            if (idx_ff < c_len) begin
               idx_in = idx_ff + 1'b1; pos_set_in = 1'b1;
            end else begin
               pos_set_in = 1'b0;
               if (!pos_set_ff) begin
                  if (!hit_ff) begin
                     if (c_dir == dir_ff) begin
                        if (lower) begin
                           pick_v_in = 1'b1; pick_r_in = crr;
                        end else begin
                           full_v_in = 1'b1; full_r_in = crr;
                        end
                     end else if (c_dir == DIR_IDLE) begin
                        idle_v_in = 1'b1; idle_r_in = crr;
                     end
                  end
                  hit_in = 1'b0; idx_in = '0;
                  if ((!hit_ff && c_dir == dir_ff && lower) ||
                      32'(crr) == NUM_RES - 1) begin
                     state_in = ST_DONE;
                  end else begin
                     cr_in = crr + 1'b1;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!ov_ff || rsp_tready) begin
               fin = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic [STAMP_W-1:0] clk_after;
   logic               bf;
   logic [1:0]         br;
   always_comb begin
      clk_after = clk_ff;
      if ((kind_ff == KIND_REQUEST || kind_ff == KIND_RELEASE) && nxt_clk > clk_ff)
         clk_after = nxt_clk;
      bf = 1'b0; br = '0;
      if (kind_ff == KIND_CHOOSE) begin
         if (pick_v_ff) begin bf = 1'b1; br = 2'(pick_r_ff); end
         else if (idle_v_ff) begin bf = 1'b1; br = 2'(idle_r_ff); end
         else if (full_v_ff) begin bf = 1'b1; br = 2'(full_r_ff); end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   // Registers, queue lengths, directions, clock and output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ov_ff <= 1'b0; clk_ff <= '0;
         for (int i = 0; i < NUM_RES; i++) begin
            len_ff[i] <= '0; rdir_ff[i] <= DIR_IDLE;
         end
         for (int i = 0; i < NUM_CAP; i++) cap_ff[i] <= CAP_W'(4);
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) cap_ff[csr_index] <= csr_wdata;
         // Load the result beat, or drop the held one once taken
         if (fin) begin
            ov_ff <= 1'b1;
            clk_ff <= clk_after;
            od_ff <= {br, bf, clk_after, (kind_ff == KIND_REQUEST) ? agent_ff : 4'd0,
                      kind_ff == KIND_REQUEST};
         end else if (ov_ff && rsp_tready) begin
            ov_ff <= 1'b0;
         end
         if (state_ff == ST_INS) begin
            len_ff[rr] <= cur_len + 1'b1;
            if (cur_len == '0) rdir_ff[rr] <= dir_ff;
         end
         if (state_ff == ST_SHDN && idx_ff >= cur_len) begin
            len_ff[rr] <= cur_len - 1'b1;
            if (cur_len == LEN_W'(1)) rdir_ff[rr] <= DIR_IDLE;
         end
      end
      kind_ff <= kind_in; agent_ff <= agent_in; res_ff <= res_in;
      dir_ff <= dir_in; stamp_ff <= stamp_in; idx_ff <= idx_in;
      pos_ff <= pos_in; pos_set_ff <= pos_set_in; hit_ff <= hit_in;
      cr_ff <= cr_in; idle_v_ff <= idle_v_in; full_v_ff <= full_v_in;
      idle_r_ff <= idle_r_in; full_r_ff <= full_r_in; pick_v_ff <= pick_v_in;
      pick_r_ff <= pick_r_in;
   end
endmodule
